>>> hw/rtl/mtke_pkg.sv
// Shared types, widths and key-set tables for the multi-tap key entry block.
package mtke_pkg;

    localparam int KEY_W    = 5;
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 5;
    localparam int IDX_W    = 2;
    localparam int LCNT_W   = 6;
    localparam int TICK_W   = 16;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

    localparam logic OP_PRESS = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [KEY_W-1:0] KEY_NONE  = 5'd0;
    localparam logic [KEY_W-1:0] KEY_FIRST = 5'd1;
    localparam logic [KEY_W-1:0] KEY_LAST  = 5'd16;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic              show_valid;
        logic [CHAR_W-1:0] show_char;
        logic [POS_W-1:0]  show_pos;
        logic              commit_valid;
        logic [CHAR_W-1:0] commit_char;
        logic [POS_W-1:0]  commit_pos;
        logic              full_res;
    } t_res_item;

    typedef struct packed {
        logic [TICK_W-1:0] timeout_ticks;
    } t_cfg_item;

    // Index of the last character in each key's set.
    function automatic logic [IDX_W-1:0] last_index(input logic [KEY_W-1:0] key);
        logic [IDX_W-1:0] idx;
        idx = 2'd1;
        if (key == KEY_NONE || key > KEY_LAST) begin
            idx = 2'd0;
        end else if (key >= 5'd13) begin
            idx = 2'd2;
        end
        return idx;
    endfunction

    // Character of a key's set at a given index; zero past the end of the set.
    function automatic logic [CHAR_W-1:0] set_char(input logic [KEY_W-1:0] key,
                                                   input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c0;
        logic [CHAR_W-1:0] c1;
        logic [CHAR_W-1:0] c2;
        logic [CHAR_W-1:0] ch;
        c0 = 8'h00;
        c1 = 8'h00;
        c2 = 8'h00;
        case (key)
            5'd1:    begin c0 = "1"; c1 = "G"; end
            5'd2:    begin c0 = "2"; c1 = "H"; end
            5'd3:    begin c0 = "3"; c1 = "I"; end
            5'd4:    begin c0 = "C"; c1 = "J"; end
            5'd5:    begin c0 = "4"; c1 = "K"; end
            5'd6:    begin c0 = "5"; c1 = "L"; end
            5'd7:    begin c0 = "6"; c1 = "M"; end
            5'd8:    begin c0 = "D"; c1 = "N"; end
            5'd9:    begin c0 = "7"; c1 = "O"; end
            5'd10:   begin c0 = "8"; c1 = "P"; end
            5'd11:   begin c0 = "9"; c1 = "Q"; end
            5'd12:   begin c0 = "E"; c1 = "R"; end
            5'd13:   begin c0 = "A"; c1 = "S"; c2 = "T"; end
            5'd14:   begin c0 = "0"; c1 = "U"; c2 = "V"; end
            5'd15:   begin c0 = "B"; c1 = "W"; c2 = "X"; end
            5'd16:   begin c0 = "F"; c1 = "Y"; c2 = "Z"; end
            default: begin c0 = 8'h00; end
        endcase
        case (idx)
            2'd0:    ch = c0;
            2'd1:    ch = c1;
            2'd2:    ch = c2;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> hw/rtl/mtke_if.sv
// Valid/ready channel interfaces for key items, results and configuration.
interface mtke_in_if;
    logic                valid;
    logic                ready;
    mtke_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mtke_res_if;
    logic                valid;
    logic                ready;
    mtke_pkg::t_res_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mtke_cfg_if;
    logic                valid;
    logic                ready;
    mtke_pkg::t_cfg_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/multi_tap_key_entry_core.sv
// Multi-tap keypad text entry: key presses and ticks in, show/commit results out.
//
// Channels: i_in takes one item per handshake, either a key press (op = 0,
// key 1..16) or one timer tick (op = 1). Every accepted item yields exactly
// one result item on o_res: the character to show at a letter position,
// the character to commit, and a flag when a new letter is refused because
// MAX_LETTERS letters have already been begun. i_cfg writes the timeout in ticks;
// always ready; the user must write it only while the block is idle (unchecked).
//
// The result of an item is registered and is on o_res in the cycle after its acceptance.
// Throughput: one item per cycle while o_res accepts; the letter state and
// the result register both update in the accepting cycle, so the next item
// follows directly. i_in.ready is high while the result register is empty or
// being drained, so a stalled receiver holds the result and back-pressures
// the input after one item.
//
// Reset: clears the pending letter, the letter count, the idle counter and
// the result valid, and loads the timeout with 1000 ticks.
module multi_tap_key_entry_core #(
    parameter int MAX_LETTERS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mtke_in_if.sink       i_in,
    mtke_cfg_if.sink      i_cfg,
    mtke_res_if.source    o_res
);

    localparam logic [mtke_pkg::LCNT_W-1:0] LCNT_MAX = mtke_pkg::LCNT_W'(MAX_LETTERS);

    logic [mtke_pkg::TICK_W-1:0] r_timeout;
    logic [mtke_pkg::KEY_W-1:0]  r_pending_key;
    logic [mtke_pkg::KEY_W-1:0]  n_pending_key;
    logic [mtke_pkg::IDX_W-1:0]  r_char_index;
    logic [mtke_pkg::IDX_W-1:0]  n_char_index;
    logic [mtke_pkg::LCNT_W-1:0] r_letter_count;
    logic [mtke_pkg::LCNT_W-1:0] n_letter_count;
    logic [mtke_pkg::TICK_W-1:0] r_idle_ticks;
    logic [mtke_pkg::TICK_W-1:0] n_idle_ticks;
    logic                        r_out_valid;
    mtke_pkg::t_res_item         r_res;
    mtke_pkg::t_res_item         n_res;

    logic                        in_accept;
    logic                        key_ok;
    logic [mtke_pkg::IDX_W-1:0]  next_index;
    logic [mtke_pkg::TICK_W-1:0] idle_inc;
    logic [mtke_pkg::POS_W-1:0]  cur_pos;
    logic                        room;

    assign i_in.ready  = !r_out_valid || o_res.ready;
    assign in_accept   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_res;

    assign key_ok     = (i_in.payload.key >= mtke_pkg::KEY_FIRST) &&
                        (i_in.payload.key <= mtke_pkg::KEY_LAST);
    assign next_index = r_char_index + 2'd1;
    assign idle_inc   = (r_idle_ticks == mtke_pkg::TICK_MAX) ? r_idle_ticks
                                                             : r_idle_ticks + 16'd1;
    assign cur_pos    = mtke_pkg::POS_W'(r_letter_count - 6'd1);
    assign room       = r_letter_count < LCNT_MAX;

    always_comb begin
        n_pending_key  = r_pending_key;
        n_char_index   = r_char_index;
        n_letter_count = r_letter_count;
        n_idle_ticks   = r_idle_ticks;
        n_res          = '0;

        if (i_in.payload.op == mtke_pkg::OP_TICK) begin
            if (r_pending_key != mtke_pkg::KEY_NONE) begin
                n_idle_ticks = idle_inc;
                // Timed out: commit the pending character
                if (idle_inc >= r_timeout) begin
                    n_res.commit_valid = 1'b1;
                    n_res.commit_char  = mtke_pkg::set_char(r_pending_key, r_char_index);
                    n_res.commit_pos   = cur_pos;
                    n_pending_key      = mtke_pkg::KEY_NONE;
                    n_char_index       = '0;
                    n_idle_ticks       = '0;
                end
            end
        end else if (key_ok) begin
            if (r_pending_key == i_in.payload.key) begin
                // Same key: step through the set, commit at its last character
                n_char_index     = next_index;
                n_idle_ticks     = '0;
                n_res.show_valid = 1'b1;
                n_res.show_char  = mtke_pkg::set_char(i_in.payload.key, next_index);
                n_res.show_pos   = cur_pos;
                if (next_index >= mtke_pkg::last_index(i_in.payload.key)) begin
                    n_res.commit_valid = 1'b1;
                    n_res.commit_char  = n_res.show_char;
                    n_res.commit_pos   = cur_pos;
                    n_pending_key      = mtke_pkg::KEY_NONE;
                    n_char_index       = '0;
                end
            end else begin
                if (r_pending_key != mtke_pkg::KEY_NONE) begin
                    n_res.commit_valid = 1'b1;
                    n_res.commit_char  = mtke_pkg::set_char(r_pending_key, r_char_index);
                    n_res.commit_pos   = cur_pos;
                end
                n_char_index = '0;
                n_idle_ticks = '0;
                if (room) begin
                    // New letter lands one position past the current one
                    n_letter_count   = r_letter_count + 6'd1;
                    n_pending_key    = i_in.payload.key;
                    n_res.show_valid = 1'b1;
                    n_res.show_char  = mtke_pkg::set_char(i_in.payload.key, '0);
                    n_res.show_pos   = r_letter_count[mtke_pkg::POS_W-1:0];
                end else begin
                    n_pending_key  = mtke_pkg::KEY_NONE;
                    n_res.full_res = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout      <= mtke_pkg::TIMEOUT_RESET;
            r_pending_key  <= mtke_pkg::KEY_NONE;
            r_char_index   <= '0;
            r_letter_count <= '0;
            r_idle_ticks   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_timeout <= i_cfg.payload.timeout_ticks;
            end
            if (in_accept) begin
                r_pending_key  <= n_pending_key;
                r_char_index   <= n_char_index;
                r_letter_count <= n_letter_count;
                r_idle_ticks   <= n_idle_ticks;
                r_out_valid    <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= n_res;
        end
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-tap key entry core: directed table, then paced random.
module tb_top;

    localparam int LETTER_CAP   = 32;
    localparam int RANDOM_ITEMS = 1800;
    localparam int TAIL_ITEMS   = 150;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 600;

    typedef struct {
        bit                          cfg_write;
        logic [mtke_pkg::TICK_W-1:0] cfg_value;
        mtke_pkg::t_in_item          item;
        bit                          has_want;
        mtke_pkg::t_res_item         want;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mtke_in_if  in_ch ();
    mtke_cfg_if cfg_ch ();
    mtke_res_if res_ch ();

    multi_tap_key_entry_core #(
        .MAX_LETTERS (LETTER_CAP)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Keypad state as the block should hold it.
    logic [mtke_pkg::TICK_W-1:0] timeout_cfg;
    logic [mtke_pkg::KEY_W-1:0]  entry_key;
    logic [mtke_pkg::IDX_W-1:0]  glyph_step;
    logic [mtke_pkg::LCNT_W-1:0] letters_begun;
    logic [mtke_pkg::TICK_W-1:0] quiet_ticks;

    mtke_pkg::t_res_item awaited_updates[$];
    int                  bad_fields       = 0;
    int                  items_accepted   = 0;
    int                  items_since_open = 0;
    int                  open_spacing     = 0;
    int                  send_calm        = 0;
    int                  recv_calm        = 0;
    bit                  long_hold_done   = 1'b0;
    t_plan_row           plan[$];

    function automatic string key_set(logic [mtke_pkg::KEY_W-1:0] k);
        string s;
        case (k)
            5'd1:  s = "1G";   5'd2:  s = "2H";   5'd3:  s = "3I";   5'd4:  s = "CJ";
            5'd5:  s = "4K";   5'd6:  s = "5L";   5'd7:  s = "6M";   5'd8:  s = "DN";
            5'd9:  s = "7O";   5'd10: s = "8P";   5'd11: s = "9Q";   5'd12: s = "ER";
            5'd13: s = "AST";  5'd14: s = "0UV";  5'd15: s = "BWX";  5'd16: s = "FYZ";
            default: s = "";
        endcase
        return s;
    endfunction

    function automatic logic [mtke_pkg::CHAR_W-1:0] glyph(logic [mtke_pkg::KEY_W-1:0] k,
                                                          logic [mtke_pkg::IDX_W-1:0] idx);
        string s;
        s = key_set(k);
        if (idx >= s.len())
            return 8'h00;
        return s[idx];
    endfunction

    function automatic int last_step(logic [mtke_pkg::KEY_W-1:0] k);
        string s;
        s = key_set(k);
        return s.len() - 1;
    endfunction

    function automatic logic [mtke_pkg::POS_W-1:0] cur_slot();
        logic [mtke_pkg::LCNT_W-1:0] n;
        n = letters_begun - 1'b1;
        return n[mtke_pkg::POS_W-1:0];
    endfunction

    function automatic void close_letter(inout mtke_pkg::t_res_item r);
        r.commit_valid = 1'b1;
        r.commit_char  = glyph(entry_key, glyph_step);
        r.commit_pos   = cur_slot();
        entry_key   = mtke_pkg::KEY_NONE;
        glyph_step  = '0;
        quiet_ticks = '0;
    endfunction

    function automatic void open_letter(logic [mtke_pkg::KEY_W-1:0] k,
                                        inout mtke_pkg::t_res_item r);
        entry_key   = mtke_pkg::KEY_NONE;
        glyph_step  = '0;
        quiet_ticks = '0;
        if (letters_begun >= LETTER_CAP) begin
            r.full_res = 1'b1;
            return;
        end
        letters_begun = letters_begun + 1'b1;
        entry_key    = k;
        r.show_valid = 1'b1;
        r.show_char  = glyph(k, '0);
        r.show_pos   = cur_slot();
    endfunction

    function automatic mtke_pkg::t_res_item next_display_update(mtke_pkg::t_in_item it);
        mtke_pkg::t_res_item r;
        r = '0;
        if (it.op == mtke_pkg::OP_TICK) begin
            if (entry_key != mtke_pkg::KEY_NONE) begin
                if (quiet_ticks != mtke_pkg::TICK_MAX)
                    quiet_ticks = quiet_ticks + 1'b1;
                if (quiet_ticks >= timeout_cfg)
                    close_letter(r);
            end
        end else if (it.key >= mtke_pkg::KEY_FIRST && it.key <= mtke_pkg::KEY_LAST) begin
            if (entry_key == mtke_pkg::KEY_NONE) begin
                open_letter(it.key, r);
            end else if (entry_key != it.key) begin
                close_letter(r);
                open_letter(it.key, r);
            end else begin
                glyph_step   = glyph_step + 1'b1;
                r.show_valid = 1'b1;
                r.show_char  = glyph(it.key, glyph_step);
                r.show_pos   = cur_slot();
                // the set's last character commits on the spot
                if (glyph_step >= last_step(it.key))
                    close_letter(r);
                else
                    quiet_ticks = '0;
            end
        end
        return r;
    endfunction

    // Mostly back-to-back, some short gaps, rare long ones, and calm stretches.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Pace new letters so capacity runs out shortly before the end of the run.
    function automatic mtke_pkg::t_in_item random_keypad_item(int remaining);
        mtke_pkg::t_in_item it;
        int                 r;
        int                 left;
        int                 spacing;
        bit                 may_open;
        left     = LETTER_CAP - letters_begun;
        may_open = (left == 0) || (remaining <= TAIL_ITEMS) ||
                   (items_since_open >= open_spacing);
        r        = $urandom_range(0, 99);
        it.op    = mtke_pkg::OP_TICK;
        it.key   = 5'($urandom_range(0, 31));
        items_since_open++;
        if (r < 4) begin
            it.op  = mtke_pkg::OP_PRESS;
            it.key = (r < 2) ? mtke_pkg::KEY_NONE : 5'($urandom_range(17, 31));
        end else if (entry_key != mtke_pkg::KEY_NONE && r >= 70 && r < 88) begin
            it.op  = mtke_pkg::OP_PRESS;
            it.key = entry_key;
        end else if ((r >= 88 || entry_key == mtke_pkg::KEY_NONE) && may_open) begin
            it.op  = mtke_pkg::OP_PRESS;
            it.key = 5'($urandom_range(1, 16));
            items_since_open = 0;
            spacing = (left > 0) ? (remaining - TAIL_ITEMS) / left : 2;
            if (spacing < 2)
                spacing = 2;
            open_spacing = $urandom_range(spacing / 2, spacing * 3 / 2);
        end
        return it;
    endfunction

    function automatic mtke_pkg::t_res_item upd(bit sv, logic [mtke_pkg::CHAR_W-1:0] sc,
                                                int sp, bit cv,
                                                logic [mtke_pkg::CHAR_W-1:0] cc,
                                                int cp, bit fr);
        mtke_pkg::t_res_item r;
        r.show_valid   = sv;
        r.show_char    = sc;
        r.show_pos     = mtke_pkg::POS_W'(sp);
        r.commit_valid = cv;
        r.commit_char  = cc;
        r.commit_pos   = mtke_pkg::POS_W'(cp);
        r.full_res     = fr;
        return r;
    endfunction

    function automatic t_plan_row step_row(logic op, int k, bit has_want,
                                           mtke_pkg::t_res_item want);
        t_plan_row row;
        row.cfg_write = 1'b0;
        row.cfg_value = '0;
        row.item.op   = op;
        row.item.key  = mtke_pkg::KEY_W'(k);
        row.has_want  = has_want;
        row.want      = want;
        return row;
    endfunction

    function automatic t_plan_row cfg_row(logic [mtke_pkg::TICK_W-1:0] v);
        t_plan_row row;
        row = step_row(mtke_pkg::OP_TICK, 0, 1'b0, '0);
        row.cfg_write = 1'b1;
        row.cfg_value = v;
        return row;
    endfunction

    task automatic push_item(mtke_pkg::t_in_item it, bit has_want,
                             mtke_pkg::t_res_item want);
        int                  gap;
        mtke_pkg::t_res_item predicted;
        gap = pick_gap(send_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = next_display_update(it);
        awaited_updates.push_back(has_want ? want : predicted);
        items_accepted++;
    endtask

    task automatic set_timeout(logic [mtke_pkg::TICK_W-1:0] v);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (awaited_updates.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid                 <= 1'b1;
        cfg_ch.payload.timeout_ticks <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        timeout_cfg = v;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            bad_fields++;
        end
    endtask

    always @(posedge i_clk) begin : res_check
        mtke_pkg::t_res_item want;
        mtke_pkg::t_res_item got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.payload;
            if (awaited_updates.size() == 0) begin
                $error("result item with none awaited: 0x%0h", got);
                bad_fields++;
            end else begin
                want = awaited_updates.pop_front();
                check_field("show_valid", want.show_valid, got.show_valid);
                check_field("show_char", want.show_char, got.show_char);
                check_field("show_pos", want.show_pos, got.show_pos);
                check_field("commit_valid", want.commit_valid, got.commit_valid);
                check_field("commit_char", want.commit_char, got.commit_char);
                check_field("commit_pos", want.commit_pos, got.commit_pos);
                check_field("full_res", want.full_res, got.full_res);
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back up the input.
    initial begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = pick_gap(recv_calm);
            if (!long_hold_done && items_accepted >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                @(negedge i_clk);
                res_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            res_ch.ready <= 1'b1;
        end
    end

    initial begin : watchdog
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        logic [mtke_pkg::TICK_W-1:0] phase_timeouts [6];
        int                          sent;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        timeout_cfg    = mtke_pkg::TIMEOUT_RESET;
        entry_key      = mtke_pkg::KEY_NONE;
        glyph_step     = '0;
        letters_begun  = '0;
        quiet_ticks    = '0;
        phase_timeouts = '{16'd5, 16'd1, 16'hFFFF, 16'd40, 16'd2, 16'd150};

        // tick with nothing pending and out-of-range keys do nothing
        plan.push_back(step_row(mtke_pkg::OP_TICK, 0, 1'b1, '0));
        plan.push_back(step_row(mtke_pkg::OP_PRESS, 0, 1'b1, '0));
        plan.push_back(step_row(mtke_pkg::OP_PRESS, 31, 1'b1, '0));
        plan.push_back(step_row(mtke_pkg::OP_PRESS, 17, 1'b1, '0));
        // two-character set: second press shows and commits
        plan.push_back(step_row(mtke_pkg::OP_PRESS, 1, 1'b1, upd(1, "1", 0, 0, 0, 0, 0)));
        plan.push_back(step_row(mtke_pkg::OP_PRESS, 1, 1'b1, upd(1, "G", 0, 1, "G", 0, 0)));
        plan.push_back(step_row(mtke_pkg::OP_PRESS, 16, 1'b1, upd(1, "F", 1, 0, 0, 0, 0)));
        plan.push_back(step_row(mtke_pkg::OP_PRESS, 16, 1'b0, '0));
        plan.push_back(step_row(mtke_pkg::OP_PRESS, 16, 1'b1, upd(1, "Z", 1, 1, "Z", 1, 0)));
        plan.push_back(step_row(mtke_pkg::OP_PRESS, 13, 1'b1, upd(1, "A", 2, 0, 0, 0, 0)));
        // different key: commit old letter, show new one at next position
        plan.push_back(step_row(mtke_pkg::OP_PRESS, 14, 1'b1, upd(1, "0", 3, 1, "A", 2, 0)));
        plan.push_back(step_row(mtke_pkg::OP_TICK, 31, 1'b0, '0));
        plan.push_back(step_row(mtke_pkg::OP_PRESS, 14, 1'b0, '0));
        plan.push_back(cfg_row(16'd1));
        plan.push_back(step_row(mtke_pkg::OP_TICK, 0, 1'b1, upd(0, 0, 0, 1, "U", 3, 0)));
        plan.push_back(step_row(mtke_pkg::OP_PRESS, 12, 1'b1, upd(1, "E", 4, 0, 0, 0, 0)));
        // zero timeout behaves like one tick
        plan.push_back(cfg_row(16'd0));
        plan.push_back(step_row(mtke_pkg::OP_TICK, 10, 1'b1, upd(0, 0, 0, 1, "E", 4, 0)));
        plan.push_back(step_row(mtke_pkg::OP_TICK, 21, 1'b1, '0));
        plan.push_back(cfg_row(16'hFFFF));
        plan.push_back(step_row(mtke_pkg::OP_PRESS, 5, 1'b1, upd(1, "4", 5, 0, 0, 0, 0)));
        plan.push_back(step_row(mtke_pkg::OP_TICK, 5, 1'b0, '0));
        plan.push_back(step_row(mtke_pkg::OP_TICK, 26, 1'b0, '0));
        plan.push_back(step_row(mtke_pkg::OP_PRESS, 15, 1'b1, upd(1, "B", 6, 1, "4", 5, 0)));
        plan.push_back(step_row(mtke_pkg::OP_PRESS, 15, 1'b0, '0));
        plan.push_back(step_row(mtke_pkg::OP_TICK, 15, 1'b0, '0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].cfg_write)
                set_timeout(plan[i].cfg_value);
            else
                push_item(plan[i].item, plan[i].has_want, plan[i].want);
        end

        sent = 0;
        foreach (phase_timeouts[p]) begin
            set_timeout(phase_timeouts[p]);
            repeat (RANDOM_ITEMS / 6) begin
                push_item(random_keypad_item(RANDOM_ITEMS - sent), 1'b0, '0);
                sent++;
            end
        end

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (awaited_updates.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (bad_fields == 0 && awaited_updates.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
